// ----- hw/rtl/pls_pkg.sv -----
// shared constants, codes and types of the positional list store
package pls_pkg;

   localparam int OPCODE_W = 3;
   localparam int POS_W    = 6;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;
   // wide enough for any index or fill level up to 64 entries
   localparam int PTR_W    = 7;

   // operations
   localparam logic [OPCODE_W-1:0] OP_APPEND      = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT      = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_LAST = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_AT   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DUMP        = 3'd4;

   // result status
   localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STS_BADPOS = 2'd3;

   // chain commands
   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_ROTATE = 2'd3;

   // per cell source select
   localparam logic [1:0] SEL_HOLD  = 2'd0;
   localparam logic [1:0] SEL_LEFT  = 2'd1;
   localparam logic [1:0] SEL_RIGHT = 2'd2;
   localparam logic [1:0] SEL_LOAD  = 2'd3;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [PTR_W-1:0] pos;
      logic [PTR_W-1:0] last;
      word_type         data;
   } chain_cmd_type;

endpackage

// ----- hw/rtl/pls_if.sv -----
// valid/ready channel interfaces for requests and responses
interface pls_req_if import pls_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [POS_W-1:0]    position;
   word_type            value;

   modport source(output valid, opcode, position, value, input ready);
   modport sink(input valid, opcode, position, value, output ready);
endinterface

interface pls_rsp_if import pls_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  entry_count;
   word_type            entry_value;
   logic                entry_valid;
   logic                last_of_run;

   modport source(output valid, status, entry_count, entry_value, entry_valid, last_of_run,
                  input ready);
   modport sink(input valid, status, entry_count, entry_value, entry_valid, last_of_run,
                output ready);
endinterface

// ----- hw/rtl/pls_cell.sv -----
// one storage cell of the list chain
module pls_cell import pls_pkg::*; (
   input  logic       clock,
   input  logic [1:0] sel,
   input  word_type   left,
   input  word_type   right,
   input  word_type   load,
   output word_type   data
);

   word_type data_ff, data_in;

   always_comb begin
      unique case (sel)
         SEL_HOLD:  data_in = data_ff;
         SEL_LEFT:  data_in = left;
         SEL_RIGHT: data_in = right;
         SEL_LOAD:  data_in = load;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- hw/rtl/pls_chain.sv -----
// row of list cells with per cell shift decode
module pls_chain import pls_pkg::*; #(
   parameter int DEPTH
) (
   input  logic          clock,
   input  chain_cmd_type cmd,
   output word_type      head
);

   word_type cell_data [DEPTH];
   word_type load_word;

   // rotate feeds the head entry back in at the tail
   assign load_word = (cmd.kind == CMD_ROTATE) ? cell_data[0] : cmd.data;
   assign head      = cell_data[0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [PTR_W-1:0] IDX = PTR_W'(i);
      logic [1:0] sel;
      word_type   left_word, right_word;

      if (i == 0) begin : g_first
         assign left_word = cell_data[i];
      end else begin : g_inner_left
         assign left_word = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = cell_data[i];
      end else begin : g_inner_right
         assign right_word = cell_data[i+1];
      end

      always_comb begin
         unique case (cmd.kind)
            CMD_NONE: sel = SEL_HOLD;
            CMD_INSERT: begin
               if (IDX > cmd.pos) sel = SEL_LEFT;
               else if (IDX == cmd.pos) sel = SEL_LOAD;
               else sel = SEL_HOLD;
            end
            CMD_REMOVE: sel = (IDX >= cmd.pos) ? SEL_RIGHT : SEL_HOLD;
            CMD_ROTATE: begin
               if (IDX < cmd.last) sel = SEL_RIGHT;
               else if (IDX == cmd.last) sel = SEL_LOAD;
               else sel = SEL_HOLD;
            end
         endcase
      end

      pls_cell u_cell (
         .clock (clock),
         .sel   (sel),
         .left  (left_word),
         .right (right_word),
         .load  (load_word),
         .data  (cell_data[i])
      );
   end

endmodule

// ----- hw/rtl/positional_list_store.sv -----
// a result is registered in the cycle after its request transaction, except for a filled list dump
// append, insert, remove, empty dump and unused opcodes each give a single result
// a filled list dump enters the dump state, then emits each stored entry in turn from the head
// the list rotates through the cell chain during a dump and ends in its original order
// reset (synchronous, active high) empties the list and drops any pending response
// cell contents are not reset; only entries below the fill level are ever read
module positional_list_store import pls_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   pls_req_if.sink      req_chan,
   pls_rsp_if.source    rsp_chan
);

   localparam int CW = $clog2(DEPTH + 1);

   // controller states
   localparam logic S_RUN  = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic          state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // response register
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [COUNT_W-1:0]  count_ff;
   word_type            value_ff;
   logic                entry_valid_ff;
   logic                last_ff;

   logic                out_free;
   logic                out_load;
   logic                req_accept;
   logic                list_full;
   logic                list_empty;
   logic [PTR_W-1:0]    fill_x;
   logic [PTR_W-1:0]    pos_x;
   logic [STATUS_W-1:0] status_d;
   word_type            value_d;
   logic                entry_valid_d;
   logic                last_d;
   chain_cmd_type       cmd;
   word_type            head;

   // the response register frees up when empty or when drained this cycle
   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_RUN) && out_free;
   assign req_accept = req_chan.valid && req_chan.ready;

   assign fill_x     = PTR_W'(fill_ff);
   assign pos_x      = PTR_W'(req_chan.position);
   assign list_full  = (fill_ff == CW'(DEPTH));
   assign list_empty = (fill_ff == '0);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      cnt_in        = cnt_ff;
      out_load      = 1'b0;
      status_d      = STS_OK;
      value_d       = '0;
      entry_valid_d = 1'b0;
      last_d        = 1'b1;
      cmd.kind      = CMD_NONE;
      cmd.pos       = '0;
      cmd.last      = '0;
      cmd.data      = req_chan.value;

      if (state_ff == S_RUN) begin
         if (req_accept) begin
            out_load = 1'b1;
            unique case (req_chan.opcode)
               OP_APPEND: begin
                  if (list_full) begin
                     status_d = STS_FULL;
                  end else begin
                     // append is an insert at the tail
                     cmd.kind = CMD_INSERT;
                     cmd.pos  = fill_x;
                     fill_in  = fill_ff + CW'(1);
                  end
               end
               OP_INSERT: begin
                  // fullness takes priority over a bad position
                  if (list_full) begin
                     status_d = STS_FULL;
                  end else if (pos_x > fill_x) begin
                     status_d = STS_BADPOS;
                  end else begin
                     cmd.kind = CMD_INSERT;
                     cmd.pos  = pos_x;
                     fill_in  = fill_ff + CW'(1);
                  end
               end
               OP_REMOVE_LAST: begin
                  if (list_empty) begin
                     status_d = STS_EMPTY;
                  end else begin
                     fill_in = fill_ff - CW'(1);
                  end
               end
               OP_REMOVE_AT: begin
                  // emptiness takes priority over a bad position
                  if (list_empty) begin
                     status_d = STS_EMPTY;
                  end else if (pos_x >= fill_x) begin
                     status_d = STS_BADPOS;
                  end else begin
                     cmd.kind = CMD_REMOVE;
                     cmd.pos  = pos_x;
                     fill_in  = fill_ff - CW'(1);
                  end
               end
               OP_DUMP: begin
                  // an empty list answers with one marker result right away
                  if (!list_empty) begin
                     out_load = 1'b0;
                     state_in = S_DUMP;
                     cnt_in   = '0;
                  end
               end
               default: begin
                  // unused opcode: plain ok response
               end
            endcase
         end
      end else if (out_free) begin
         // emit the head entry and rotate the list by one
         cmd.kind      = CMD_ROTATE;
         cmd.last      = fill_x - PTR_W'(1);
         out_load      = 1'b1;
         value_d       = head;
         entry_valid_d = 1'b1;
         last_d        = (cnt_ff == fill_ff - CW'(1));
         cnt_in        = cnt_ff + CW'(1);
         if (last_d) begin
            state_in = S_RUN;
         end
      end
   end

   assign out_valid_in = out_load || (out_valid_ff && !rsp_chan.ready);

   pls_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock (clock),
      .cmd   (cmd),
      .head  (head)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // response payload, loaded only with a new result
   always_ff @(posedge clock) begin
      if (out_load) begin
         status_ff      <= status_d;
         count_ff       <= COUNT_W'(fill_in);
         value_ff       <= value_d;
         entry_valid_ff <= entry_valid_d;
         last_ff        <= last_d;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.entry_count = count_ff;
   assign rsp_chan.entry_value = value_ff;
   assign rsp_chan.entry_valid = entry_valid_ff;
   assign rsp_chan.last_of_run = last_ff;

   // fill level never passes the capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill level above capacity");

   // no new transaction is taken while a dump is running
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |-> !req_chan.ready)
      else $error("request accepted during dump");

   // a dump of a non-empty list enters the dump state
   a_dump_start: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_chan.opcode == OP_DUMP && !list_empty |=> state_ff == S_DUMP)
      else $error("dump did not start");

   // a dump leaves the fill level untouched
   a_dump_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |=> fill_ff == $past(fill_ff))
      else $error("fill level changed during dump");

   // the dump counter stays below the fill level
   a_dump_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |-> cnt_ff < fill_ff)
      else $error("dump counter past fill level");

endmodule
